[src/fbfs_pkg.sv]
// ----------------------------------------------------------------------------
// fbfs_pkg: shared types and constants
// Command codes, register indexes, field widths and the sequencer state type
// of the framebuffer fill and scroll engine.
// ----------------------------------------------------------------------------
`default_nettype none

package fbfs_pkg;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int COORD_W  = 13;
  localparam int DIM_W    = 12;
  localparam int COLOR_W  = 32;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W   = 24;   // 12 x 12 product
  localparam int WADDR_W  = 25;   // full word address before capacity check
  localparam int CLIP_W   = 15;   // signed clip arithmetic

  // Register reset value
  localparam logic [DIM_W-1:0] DIM_RESET = 12'd64;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUT    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FILL   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SCROLL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADDR,
    ST_ADDR_USE,
    ST_READ_WAIT,
    ST_CLIP,
    ST_ROW_MUL,
    ST_ROW_BASE,
    ST_FILL,
    ST_SC_SRC,
    ST_SC_CNT,
    ST_SC_INIT,
    ST_COPY,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

[src/fbfs_mult.sv]
// ----------------------------------------------------------------------------
// fbfs_mult: shared address multiplier
// Registered 12 x 12 unsigned product, used for row * stride terms.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfs_mult (
  input  wire logic                         clk,
  input  wire logic [fbfs_pkg::DIM_W-1:0]   a,
  input  wire logic [fbfs_pkg::DIM_W-1:0]   b,
  output logic      [fbfs_pkg::PROD_W-1:0]  p
);

  // One product per cycle, result valid the cycle after the operands
  always_ff @(posedge clk) begin
    p <= fbfs_pkg::PROD_W'(a) * fbfs_pkg::PROD_W'(b);
  end

endmodule

`default_nettype wire

[src/fbfs_mem.sv]
// ----------------------------------------------------------------------------
// fbfs_mem: pixel store
// Simple dual-port word memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfs_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [AW-1:0]                  waddr,
  input  wire logic [fbfs_pkg::COLOR_W-1:0]   wdata,
  input  wire logic [AW-1:0]                  raddr,
  output logic      [fbfs_pkg::COLOR_W-1:0]   rdata
);

  logic [fbfs_pkg::COLOR_W-1:0] mem_array [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_array[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_array[raddr];
  end

endmodule

`default_nettype wire

[src/framebuffer_fill_scroll_engine_unit.sv]
// One item at a time: in_ready returns the cycle after the result is registered, and a
// result still waiting at the output holds the sequencer in its last state.
// Reset clears the sequencer and sets width, height and stride to 64; the store is kept.
// ----------------------------------------------------------------------------
// framebuffer_fill_scroll_engine_unit: 2D fill and scroll engine
// Sequencer over a shared address multiplier and one pixel store, running
// put, fill, clear, scroll and read commands one word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module framebuffer_fill_scroll_engine_unit #(
  parameter int FB_WORDS = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [fbfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [fbfs_pkg::DIM_W-1:0]        cfg_data,
  // command items
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [fbfs_pkg::CMD_W-1:0]        command,
  input  wire logic signed [fbfs_pkg::COORD_W-1:0] x_pos,
  input  wire logic signed [fbfs_pkg::COORD_W-1:0] y_pos,
  input  wire logic signed [fbfs_pkg::COORD_W-1:0] rect_width,
  input  wire logic signed [fbfs_pkg::COORD_W-1:0] rect_height,
  input  wire logic [fbfs_pkg::DIM_W-1:0]        scroll_rows,
  input  wire logic [fbfs_pkg::COLOR_W-1:0]      color,
  // result items
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [fbfs_pkg::COLOR_W-1:0]           read_pixel,
  output logic                                   status
);

  localparam int MEM_AW = $clog2(FB_WORDS);
  localparam logic [fbfs_pkg::WADDR_W-1:0] FB_LIMIT = fbfs_pkg::WADDR_W'(FB_WORDS);

  fbfs_pkg::state_t state, state_next;

  // configuration registers
  logic [fbfs_pkg::DIM_W-1:0] sw, sh, stride;

  // latched command
  logic [fbfs_pkg::CMD_W-1:0]          cmd_r;
  logic signed [fbfs_pkg::COORD_W-1:0] x_r, y_r, w_r, h_r;
  logic [fbfs_pkg::DIM_W-1:0]          rows_r;
  logic [fbfs_pkg::COLOR_W-1:0]        color_r;

  // rectangle before and after clipping
  logic signed [fbfs_pkg::COORD_W-1:0] f_x, f_y, f_w, f_h;
  logic [fbfs_pkg::DIM_W-1:0]          c_x, c_y, c_w;
  logic                                scroll_fill;

  // fill walker
  logic [fbfs_pkg::WADDR_W-1:0] base, cur;
  logic [fbfs_pkg::DIM_W-1:0]   col_left, rows_left;

  // scroll copy
  logic [fbfs_pkg::WADDR_W-1:0] src, copy_words, rd_i;
  logic                         pend, pend_zero;
  logic [MEM_AW-1:0]            pend_addr;

  // result staging
  logic [fbfs_pkg::COLOR_W-1:0] res_pix;
  logic                         res_status;

  // shared units
  logic [fbfs_pkg::DIM_W-1:0]   mul_a, mul_b;
  logic [fbfs_pkg::PROD_W-1:0]  prod;
  logic                         mem_we;
  logic [MEM_AW-1:0]            mem_waddr, mem_raddr;
  logic [fbfs_pkg::COLOR_W-1:0] mem_wdata, mem_rdata;

  // derived control terms
  logic                         in_surface, addr_ok, row_base_over, row_end, last_row;
  logic                         next_base_over, copy_done;
  logic [fbfs_pkg::WADDR_W-1:0] pix_addr, row_base_addr, next_base, rd_addr;
  logic [fbfs_pkg::DIM_W-1:0]   kept_rows;

  // clip arithmetic
  logic signed [fbfs_pkg::CLIP_W-1:0] clip_xs, clip_ys, clip_ws, clip_hs;
  logic signed [fbfs_pkg::CLIP_W-1:0] sw_s, sh_s;
  logic                               clip_empty;

  fbfs_mult u_mult (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  fbfs_mem #(
    .DEPTH (FB_WORDS),
    .AW    (MEM_AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sw     <= fbfs_pkg::DIM_RESET;
      sh     <= fbfs_pkg::DIM_RESET;
      stride <= fbfs_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        fbfs_pkg::REG_WIDTH:  sw     <= cfg_data;
        fbfs_pkg::REG_HEIGHT: sh     <= cfg_data;
        fbfs_pkg::REG_STRIDE: stride <= cfg_data;
        default: ;
      endcase
    end
  end

  // Point checks and address terms
  assign in_surface = (x_r >= 13'sd0) && (y_r >= 13'sd0) &&
                      (x_r < $signed({1'b0, sw})) && (y_r < $signed({1'b0, sh}));
  assign pix_addr      = fbfs_pkg::WADDR_W'(prod) + fbfs_pkg::WADDR_W'(x_r[11:0]);
  assign addr_ok       = pix_addr < FB_LIMIT;
  assign row_base_addr = fbfs_pkg::WADDR_W'(prod) + fbfs_pkg::WADDR_W'(c_x);
  assign row_base_over = row_base_addr >= FB_LIMIT;
  assign next_base     = base + fbfs_pkg::WADDR_W'(stride);
  assign next_base_over = next_base >= FB_LIMIT;
  assign row_end       = (col_left == 12'd1) || ((cur + 25'd1) >= FB_LIMIT);
  assign last_row      = rows_left == 12'd1;
  assign rd_addr       = fbfs_pkg::WADDR_W'(src) + rd_i;
  assign copy_done     = (rd_i == copy_words) && !pend;
  assign kept_rows     = sh - rows_r;

  // Rectangle clip against the surface
  always_comb begin
    sw_s    = {3'b000, sw};
    sh_s    = {3'b000, sh};
    clip_xs = {{2{f_x[12]}}, f_x};
    clip_ys = {{2{f_y[12]}}, f_y};
    clip_ws = {{2{f_w[12]}}, f_w};
    clip_hs = {{2{f_h[12]}}, f_h};
    clip_empty = 1'b0;
    if (clip_xs < 15'sd0) begin
      clip_ws = clip_ws + clip_xs;
      clip_xs = 15'sd0;
    end
    if (clip_ys < 15'sd0) begin
      clip_hs = clip_hs + clip_ys;
      clip_ys = 15'sd0;
    end
    if (clip_xs >= sw_s || clip_ys >= sh_s) begin
      clip_empty = 1'b1;
    end
    if (clip_ws > sw_s - clip_xs) begin
      clip_ws = sw_s - clip_xs;
    end
    if (clip_hs > sh_s - clip_ys) begin
      clip_hs = sh_s - clip_ys;
    end
    if (clip_ws <= 15'sd0 || clip_hs <= 15'sd0) begin
      clip_empty = 1'b1;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fbfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, multiplier operands and store port
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mul_a      = '0;
    mul_b      = stride;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = color_r;
    mem_raddr  = '0;
    case (state)
      fbfs_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid) begin
          state_next = fbfs_pkg::ST_DISPATCH;
        end
      end
      fbfs_pkg::ST_DISPATCH: begin
        case (cmd_r)
          fbfs_pkg::CMD_PUT, fbfs_pkg::CMD_READ:
            state_next = in_surface ? fbfs_pkg::ST_ADDR : fbfs_pkg::ST_FINISH;
          fbfs_pkg::CMD_FILL, fbfs_pkg::CMD_CLEAR:
            state_next = fbfs_pkg::ST_CLIP;
          fbfs_pkg::CMD_SCROLL: begin
            if (rows_r == '0) begin
              state_next = fbfs_pkg::ST_FINISH;
            end else if (rows_r >= sh) begin
              state_next = fbfs_pkg::ST_CLIP;
            end else begin
              state_next = fbfs_pkg::ST_SC_SRC;
            end
          end
          default: state_next = fbfs_pkg::ST_FINISH;
        endcase
      end
      fbfs_pkg::ST_ADDR: begin
        mul_a      = y_r[11:0];
        state_next = fbfs_pkg::ST_ADDR_USE;
      end
      fbfs_pkg::ST_ADDR_USE: begin
        mem_raddr = pix_addr[MEM_AW-1:0];
        mem_waddr = pix_addr[MEM_AW-1:0];
        if (cmd_r == fbfs_pkg::CMD_PUT && addr_ok) begin
          mem_we = 1'b1;
        end
        if (cmd_r == fbfs_pkg::CMD_READ && addr_ok) begin
          state_next = fbfs_pkg::ST_READ_WAIT;
        end else begin
          state_next = fbfs_pkg::ST_FINISH;
        end
      end
      fbfs_pkg::ST_READ_WAIT: state_next = fbfs_pkg::ST_FINISH;
      fbfs_pkg::ST_CLIP: begin
        state_next = clip_empty ? fbfs_pkg::ST_FINISH : fbfs_pkg::ST_ROW_MUL;
      end
      fbfs_pkg::ST_ROW_MUL: begin
        mul_a      = c_y;
        state_next = fbfs_pkg::ST_ROW_BASE;
      end
      fbfs_pkg::ST_ROW_BASE: begin
        state_next = row_base_over ? fbfs_pkg::ST_FINISH : fbfs_pkg::ST_FILL;
      end
      fbfs_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cur[MEM_AW-1:0];
        if (row_end && (last_row || next_base_over)) begin
          state_next = fbfs_pkg::ST_FINISH;
        end
      end
      fbfs_pkg::ST_SC_SRC: begin
        mul_a      = rows_r;
        state_next = fbfs_pkg::ST_SC_CNT;
      end
      fbfs_pkg::ST_SC_CNT: begin
        mul_a      = kept_rows;
        state_next = fbfs_pkg::ST_SC_INIT;
      end
      fbfs_pkg::ST_SC_INIT: state_next = fbfs_pkg::ST_COPY;
      fbfs_pkg::ST_COPY: begin
        // read runs one word ahead of the write; source is always above target
        mem_raddr = rd_addr[MEM_AW-1:0];
        mem_we    = pend;
        mem_waddr = pend_addr;
        mem_wdata = pend_zero ? '0 : mem_rdata;
        if (copy_done) begin
          state_next = fbfs_pkg::ST_CLIP;
        end
      end
      fbfs_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = fbfs_pkg::ST_IDLE;
        end
      end
      default: state_next = fbfs_pkg::ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      fbfs_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd_r       <= command;
          x_r         <= x_pos;
          y_r         <= y_pos;
          w_r         <= rect_width;
          h_r         <= rect_height;
          rows_r      <= scroll_rows;
          color_r     <= color;
          scroll_fill <= 1'b0;
        end
      end
      fbfs_pkg::ST_DISPATCH: begin
        res_pix    <= '0;
        res_status <= 1'b1;
        // clear, or a scroll that covers the whole height
        if (cmd_r == fbfs_pkg::CMD_CLEAR ||
            (cmd_r == fbfs_pkg::CMD_SCROLL && rows_r >= sh)) begin
          f_x <= '0;
          f_y <= '0;
          f_w <= {1'b0, sw};
          f_h <= {1'b0, sh};
        end else begin
          f_x <= x_r;
          f_y <= y_r;
          f_w <= w_r;
          f_h <= h_r;
        end
      end
      fbfs_pkg::ST_ADDR_USE: begin
        if (cmd_r == fbfs_pkg::CMD_PUT) begin
          res_status <= 1'b0;
        end
      end
      fbfs_pkg::ST_READ_WAIT: begin
        res_pix    <= mem_rdata;
        res_status <= 1'b0;
      end
      fbfs_pkg::ST_CLIP: begin
        c_x        <= clip_xs[11:0];
        c_y        <= clip_ys[11:0];
        c_w        <= clip_ws[11:0];
        rows_left  <= (stride == '0) ? 12'd1 : clip_hs[11:0];
        res_status <= clip_empty && !scroll_fill;
      end
      fbfs_pkg::ST_ROW_BASE: begin
        base     <= row_base_addr;
        cur      <= row_base_addr;
        col_left <= c_w;
      end
      fbfs_pkg::ST_FILL: begin
        if (row_end) begin
          base      <= next_base;
          cur       <= next_base;
          col_left  <= c_w;
          rows_left <= rows_left - 12'd1;
        end else begin
          cur      <= cur + 25'd1;
          col_left <= col_left - 12'd1;
        end
      end
      fbfs_pkg::ST_SC_CNT: begin
        src <= fbfs_pkg::WADDR_W'(prod);
      end
      fbfs_pkg::ST_SC_INIT: begin
        copy_words <= (fbfs_pkg::WADDR_W'(prod) >= FB_LIMIT) ?
                      FB_LIMIT : fbfs_pkg::WADDR_W'(prod);
        rd_i <= '0;
        pend <= 1'b0;
      end
      fbfs_pkg::ST_COPY: begin
        if (rd_i != copy_words) begin
          rd_i      <= rd_i + 25'd1;
          pend      <= 1'b1;
          pend_addr <= rd_i[MEM_AW-1:0];
          pend_zero <= rd_addr >= FB_LIMIT;
        end else begin
          pend <= 1'b0;
        end
        // bottom rows freed by the scroll
        if (copy_done) begin
          f_x         <= '0;
          f_y         <= {1'b0, kept_rows};
          f_w         <= {1'b0, sw};
          f_h         <= {1'b0, rows_r};
          scroll_fill <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == fbfs_pkg::ST_FINISH && (!out_valid || out_ready)) begin
      out_valid  <= 1'b1;
      read_pixel <= res_pix;
      status     <= res_status;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire
